### rtl/sb5_pkg.sv
// shared types, constants and tap arithmetic for the separable 5x5 blur
// no dependencies
`default_nettype none

package sb5_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 12;
   localparam int WIDTH_W     = 12;
   localparam int HEIGHT_W    = 13;
   localparam int PIX_W       = 24;
   localparam int SLOTS       = 4;
   localparam int MAX_RES     = 4;
   localparam int RES_CNT_W   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [WIDTH_W-1:0]  MIN_WIDTH   = 12'd5;
   localparam logic [WIDTH_W-1:0]  CAP_WIDTH   = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] MIN_HEIGHT  = 13'd5;
   localparam logic [HEIGHT_W-1:0] CAP_HEIGHT  = 13'd4096;
   localparam logic [WIDTH_W-1:0]  RESET_WIDTH = 12'd640;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_blue;
      logic [7:0]       out_green;
      logic [7:0]       out_red;
      logic [ROW_W-1:0] pixel_row;
      logic [COL_W-1:0] pixel_col;
      logic             run_last;
   } rsp_type;

   typedef struct packed {
      pix_type          pix;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } res_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]       count;
      res_type [MAX_RES-1:0]      slot;
   } bundle_type;

   typedef struct packed {
      logic [COL_W-1:0] x;
      logic [ROW_W-1:0] r;
      logic             a_en;
      logic             b_en;
      logic             lo;
      logic             mid;
      logic             hi;
   } pos_type;

   function automatic logic [7:0] div10(input logic [11:0] s);
      logic [23:0] prod;
      prod = {12'b0, s} * 24'd3277;
      return prod[22:15];
   endfunction

   function automatic pix_type tap5(input pix_type [4:0] p);
      pix_type     res;
      logic [11:0] s;
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
         s = {4'b0, p[0][8*ch +: 8]} + {3'b0, p[1][8*ch +: 8], 1'b0}
           + {2'b0, p[2][8*ch +: 8], 2'b0} + {3'b0, p[3][8*ch +: 8], 1'b0}
           + {4'b0, p[4][8*ch +: 8]};
         res[8*ch +: 8] = div10(s);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/sb5_line_buf.sv
// four-row line memory with read-modify-write per pixel and vertical tap
// depends on sb5_pkg
`default_nettype none

module sb5_line_buf (
   input  wire logic                    clock,
   input  wire logic                    rd_en,
   input  wire logic [sb5_pkg::COL_W-1:0] rd_addr,
   input  wire logic                    wr_en,
   input  wire logic [sb5_pkg::COL_W-1:0] wr_addr,
   input  wire logic [1:0]              wr_slot,
   input  wire sb5_pkg::pix_type        wr_pix,
   output sb5_pkg::pix_type             vert
);

   sb5_pkg::pix_type [sb5_pkg::SLOTS-1:0] mem [sb5_pkg::MAX_WIDTH];
   sb5_pkg::pix_type [sb5_pkg::SLOTS-1:0] rdata_ff;
   sb5_pkg::pix_type [sb5_pkg::SLOTS-1:0] wdata_in;
   sb5_pkg::pix_type [4:0]                col_in;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wdata_in;
      end
   end

   always_comb begin
      wdata_in          = rdata_ff;
      wdata_in[wr_slot] = wr_pix;
      for (int k = 0; k < 4; k++) begin
         col_in[k] = rdata_ff[2'(wr_slot + 2'(k))];
      end
      col_in[4] = wr_pix;
   end

   assign vert = sb5_pkg::tap5(col_in);

endmodule

`default_nettype wire

### rtl/sb5_cell.sv
// one tap cell of the horizontal windows: vertical result and raw pixel
// depends on sb5_pkg
`default_nettype none

module sb5_cell (
   input  wire logic             clock,
   input  wire logic             shift_en,
   input  wire sb5_pkg::pix_type a_in,
   input  wire sb5_pkg::pix_type b_in,
   output sb5_pkg::pix_type      a_out,
   output sb5_pkg::pix_type      b_out
);

   sb5_pkg::pix_type a_ff;
   sb5_pkg::pix_type b_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign a_out = a_ff;
   assign b_out = b_ff;

endmodule

`default_nettype wire

### rtl/sb5_out_queue.sv
// result queue of per-pixel bundles, drained one word per cycle while rsp_stall is low
// depends on sb5_pkg
`default_nettype none

module sb5_out_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire sb5_pkg::bundle_type        push_data,
   output logic [sb5_pkg::QCNT_W-1:0]      count,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output sb5_pkg::rsp_type                rsp_data
);

   sb5_pkg::bundle_type             entry_ff [sb5_pkg::QUEUE_DEPTH];
   logic [sb5_pkg::QPTR_W-1:0]      wp_ff, wp_in;
   logic [sb5_pkg::QPTR_W-1:0]      rp_ff, rp_in;
   logic [sb5_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic [1:0]                      idx_ff, idx_in;
   sb5_pkg::bundle_type             head;
   sb5_pkg::res_type                cur;
   logic                            last;
   logic                            pop_word;
   logic                            pop_bundle;

   assign head       = entry_ff[rp_ff];
   assign cur        = head.slot[idx_ff];
   assign last       = ({1'b0, idx_ff} == head.count - 3'd1);
   assign rsp_valid  = (cnt_ff != '0);
   assign pop_word   = rsp_valid && !rsp_stall;
   assign pop_bundle = pop_word && last;
   assign count      = cnt_ff;

   always_comb begin
      rsp_data.out_blue  = cur.pix[7:0];
      rsp_data.out_green = cur.pix[15:8];
      rsp_data.out_red   = cur.pix[23:16];
      rsp_data.pixel_row = cur.row;
      rsp_data.pixel_col = cur.col;
      rsp_data.run_last  = last;
   end

   always_comb begin
      wp_in  = push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = pop_bundle ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop_bundle};
      priority if (pop_bundle) begin
         idx_in = '0;
      end else if (pop_word) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/separable_5x5_blur.sv
// separable 5x5 blur: accepted pixel -> pix1/pos1 -> pos2 -> queue -> first word
// one pixel per clock unless stalled, one result word per clock unless rsp_stall;
// a pixel yielding several words holds the input back through the 4-entry queue
// the line memory does one read-modify-write per pixel, one port each way
// reset is synchronous and active high; line memory is not cleared
// depends on sb5_pkg, sb5_line_buf, sb5_cell, sb5_out_queue
`default_nettype none

module separable_5x5_blur (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire sb5_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output sb5_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [sb5_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [sb5_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [sb5_pkg::DATA_W-1:0]         csr_prdata,
   output logic                               csr_pready
);

   logic [sb5_pkg::WIDTH_W-1:0]  width_ff;
   logic [sb5_pkg::HEIGHT_W-1:0] height_ff;
   logic [sb5_pkg::WIDTH_W-1:0]  w;
   logic [sb5_pkg::HEIGHT_W-1:0] h;
   logic [sb5_pkg::COL_W-1:0]    col_ff, col_in;
   logic [sb5_pkg::ROW_W-1:0]    row_ff, row_in;
   logic                         cfg_wr;
   logic                         accept;
   sb5_pkg::pos_type             pos0;
   sb5_pkg::pos_type             pos1_ff;
   sb5_pkg::pos_type             pos2_ff;
   sb5_pkg::pix_type             pix1_ff;
   logic                         v1_ff;
   logic                         v2_ff;
   sb5_pkg::pix_type             vert;
   sb5_pkg::pix_type [4:0]       win_a;
   sb5_pkg::pix_type [4:0]       win_b;
   logic [sb5_pkg::QCNT_W-1:0]   q_count;
   sb5_pkg::bundle_type          bundle;
   sb5_pkg::res_type [3:0]       cand;
   logic [3:0]                   cand_v;
   logic [sb5_pkg::RES_CNT_W-1:0] n;
   sb5_pkg::pix_type             tap_a;
   sb5_pkg::pix_type             tap_b;
   logic [sb5_pkg::COL_W-1:0]    x2;
   logic [sb5_pkg::WIDTH_W-1:0]  x_ext;
   logic [sb5_pkg::HEIGHT_W-1:0] r_ext;

   // config port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2])
         sb5_pkg::REG_WIDTH:  csr_prdata = {20'b0, width_ff};
         sb5_pkg::REG_HEIGHT: csr_prdata = {19'b0, height_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sb5_pkg::RESET_WIDTH;
         height_ff <= sb5_pkg::RESET_HEIGHT;
      end else if (cfg_wr) begin
         if (csr_paddr[2] == sb5_pkg::REG_WIDTH) begin
            width_ff <= csr_pwdata[sb5_pkg::WIDTH_W-1:0];
         end else begin
            height_ff <= csr_pwdata[sb5_pkg::HEIGHT_W-1:0];
         end
      end
   end

   always_comb begin
      priority if (width_ff < sb5_pkg::MIN_WIDTH) begin
         w = sb5_pkg::MIN_WIDTH;
      end else if (width_ff > sb5_pkg::CAP_WIDTH) begin
         w = sb5_pkg::CAP_WIDTH;
      end else begin
         w = width_ff;
      end
      priority if (height_ff < sb5_pkg::MIN_HEIGHT) begin
         h = sb5_pkg::MIN_HEIGHT;
      end else if (height_ff > sb5_pkg::CAP_HEIGHT) begin
         h = sb5_pkg::CAP_HEIGHT;
      end else begin
         h = height_ff;
      end
   end

   // input side and raster position
   assign req_stall = ({1'b0, q_count} + {3'b0, v1_ff} + {3'b0, v2_ff})
                      >= 4'(sb5_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign x_ext     = {1'b0, col_ff};
   assign r_ext     = {1'b0, row_ff};

   always_comb begin
      pos0.x    = col_ff;
      pos0.r    = row_ff;
      pos0.a_en = (row_ff >= 12'd4);
      pos0.b_en = (row_ff < 12'd2) || (r_ext >= h - 13'd2);
      pos0.lo   = (col_ff <= 11'd1);
      pos0.mid  = (col_ff >= 11'd4);
      pos0.hi   = (x_ext == w - 12'd2) || (x_ext == w - 12'd1);
      col_in    = col_ff;
      row_in    = row_ff;
      if (cfg_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (x_ext + 12'd1 >= w) begin
            col_in = '0;
            row_in = (r_ext + 13'd1 >= h) ? '0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         v1_ff  <= accept;
         v2_ff  <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos1_ff <= pos0;
         pix1_ff <= req_data;
      end
      pos2_ff <= pos1_ff;
   end

   sb5_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (v1_ff),
      .wr_addr (pos1_ff.x),
      .wr_slot (pos1_ff.r[1:0]),
      .wr_pix  (pix1_ff),
      .vert    (vert)
   );

   // horizontal windows, newest in cell 0
   for (genvar k = 0; k < 5; k++) begin : g_cell
      if (k == 0) begin : g_head
         sb5_cell u_cell (
            .clock    (clock),
            .shift_en (v1_ff),
            .a_in     (vert),
            .b_in     (pix1_ff),
            .a_out    (win_a[k]),
            .b_out    (win_b[k])
         );
      end else begin : g_tail
         sb5_cell u_cell (
            .clock    (clock),
            .shift_en (v1_ff),
            .a_in     (win_a[k-1]),
            .b_in     (win_b[k-1]),
            .a_out    (win_a[k]),
            .b_out    (win_b[k])
         );
      end
   end

   // build the words caused by one pixel, row r-2 first, then row r
   assign tap_a = sb5_pkg::tap5(win_a);
   assign tap_b = sb5_pkg::tap5(win_b);
   assign x2    = pos2_ff.x - 11'd2;

   always_comb begin
      cand[0].pix = pos2_ff.mid ? tap_a : win_a[0];
      cand[0].row = pos2_ff.r - 12'd2;
      cand[0].col = pos2_ff.mid ? x2 : pos2_ff.x;
      cand[1].pix = win_a[0];
      cand[1].row = pos2_ff.r - 12'd2;
      cand[1].col = pos2_ff.x;
      cand[2].pix = pos2_ff.mid ? tap_b : win_b[0];
      cand[2].row = pos2_ff.r;
      cand[2].col = pos2_ff.mid ? x2 : pos2_ff.x;
      cand[3].pix = win_b[0];
      cand[3].row = pos2_ff.r;
      cand[3].col = pos2_ff.x;
      cand_v[0] = pos2_ff.a_en && (pos2_ff.lo || pos2_ff.mid || pos2_ff.hi);
      cand_v[1] = pos2_ff.a_en && pos2_ff.mid && pos2_ff.hi;
      cand_v[2] = pos2_ff.b_en && (pos2_ff.lo || pos2_ff.mid || pos2_ff.hi);
      cand_v[3] = pos2_ff.b_en && pos2_ff.mid && pos2_ff.hi;
      bundle = '0;
      n      = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i]) begin
            bundle.slot[n[1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
      bundle.count = n;
   end

   sb5_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (v2_ff && (n != '0)),
      .push_data (bundle),
      .count     (q_count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### sim/sb5_blur_checker.sv
// checker for the separable 5x5 blur: watches the pixel, result and register ports,
// predicts every result word and compares it field by field; depends on sb5_pkg
`timescale 1ns / 100ps

module sb5_blur_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire sb5_pkg::req_type           req_data,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire sb5_pkg::rsp_type           rsp_data,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [sb5_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [sb5_pkg::DATA_W-1:0] csr_pwdata,
   input  wire logic                       csr_pready,
   output int                              mismatches,
   output int                              words_pending,
   output int                              pixels_seen,
   output int                              words_seen
);

   logic [23:0]      line_rows [4][sb5_pkg::MAX_WIDTH];
   logic [23:0]      vert_win [5];
   logic [23:0]      pix_win [5];
   int               row_at;
   int               col_at;
   logic [11:0]      width_reg;
   logic [12:0]      height_reg;
   sb5_pkg::rsp_type expected_words [$];

   function automatic logic [23:0] blur5(input logic [23:0] p [5]);
      logic [23:0] res;
      int          sum;
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
         sum = p[0][8*ch +: 8] + 2 * p[1][8*ch +: 8] + 4 * p[2][8*ch +: 8]
             + 2 * p[3][8*ch +: 8] + p[4][8*ch +: 8];
         res[8*ch +: 8] = 8'(sum / 10);
      end
      return res;
   endfunction

   function automatic void add_word(input logic [23:0] pix, input int row, input int col);
      sb5_pkg::rsp_type w;
      w.out_blue  = pix[7:0];
      w.out_green = pix[15:8];
      w.out_red   = pix[23:16];
      w.pixel_row = row[sb5_pkg::ROW_W-1:0];
      w.pixel_col = col[sb5_pkg::COL_W-1:0];
      w.run_last  = 1'b0;
      expected_words.push_back(w);
   endfunction

   function automatic void row_words(input logic [23:0] win [5], input int row,
                                     input int x, input int w);
      if (x == 0 || x == 1) add_word(win[0], row, x);
      if (x >= 4) add_word(blur5(win), row, x - 2);
      if (x == w - 2 || x == w - 1) add_word(win[0], row, x);
   endfunction

   function automatic void blur_pixel(input logic [23:0] pix);
      int          w;
      int          h;
      int          r;
      int          x;
      int          before_n;
      logic [23:0] column [5];
      w = (width_reg < 5) ? 5 : (width_reg > sb5_pkg::MAX_WIDTH) ? sb5_pkg::MAX_WIDTH
                                                                  : int'(width_reg);
      h = (height_reg < 5) ? 5 : (height_reg > 4096) ? 4096 : int'(height_reg);
      r = (row_at >= h) ? 0 : row_at;
      x = (col_at >= w) ? 0 : col_at;
      for (int k = 0; k < 4; k++) column[k] = line_rows[(r + k) & 3][x];
      column[4] = pix;
      line_rows[r & 3][x] = pix;
      for (int k = 4; k > 0; k--) begin
         vert_win[k] = vert_win[k-1];
         pix_win[k]  = pix_win[k-1];
      end
      vert_win[0] = blur5(column);
      pix_win[0]  = pix;
      before_n = expected_words.size();
      if (r >= 4) row_words(vert_win, r - 2, x, w);
      if (r < 2 || r >= h - 2) row_words(pix_win, r, x, w);
      if (expected_words.size() > before_n)
         expected_words[expected_words.size()-1].run_last = 1'b1;
      x++;
      if (x >= w) begin
         x = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_at = r;
      col_at = x;
   endfunction

   initial begin
      mismatches = 0;
      words_pending = 0;
      pixels_seen = 0;
      words_seen = 0;
      for (int s = 0; s < 4; s++)
         for (int c = 0; c < sb5_pkg::MAX_WIDTH; c++) line_rows[s][c] = '0;
      for (int k = 0; k < 5; k++) begin
         vert_win[k] = '0;
         pix_win[k] = '0;
      end
   end

   always @(posedge clock) begin
      sb5_pkg::rsp_type got;
      sb5_pkg::rsp_type want;
      if (reset) begin
         row_at = 0;
         col_at = 0;
         width_reg = sb5_pkg::RESET_WIDTH;
         height_reg = sb5_pkg::RESET_HEIGHT;
         expected_words.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == sb5_pkg::REG_WIDTH) begin
               width_reg = csr_pwdata[11:0];
               row_at = 0;
               col_at = 0;
            end else if (csr_paddr[2] == sb5_pkg::REG_HEIGHT) begin
               height_reg = csr_pwdata[12:0];
               row_at = 0;
               col_at = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            words_seen++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word b%h g%h r%h row %0d col %0d last %b",
                     got.out_blue, got.out_green, got.out_red, got.pixel_row,
                     got.pixel_col, got.run_last);
            end else begin
               want = expected_words.pop_front();
               if (got.out_blue !== want.out_blue || got.out_green !== want.out_green
                   || got.out_red !== want.out_red || got.pixel_row !== want.pixel_row
                   || got.pixel_col !== want.pixel_col
                   || got.run_last !== want.run_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected b%h g%h r%h row %0d col %0d last %b,",
                               " got b%h g%h r%h row %0d col %0d last %b"},
                        want.out_blue, want.out_green, want.out_red, want.pixel_row,
                        want.pixel_col, want.run_last, got.out_blue, got.out_green,
                        got.out_red, got.pixel_row, got.pixel_col, got.run_last);
               end
            end
         end
         if (req_valid && !req_stall) begin
            pixels_seen++;
            blur_pixel({req_data.in_red, req_data.in_green, req_data.in_blue});
         end
      end
      words_pending = expected_words.size();
   end

endmodule

### sim/tb_separable_5x5_blur.sv
// testbench top for the separable 5x5 blur: clock, reset, register writes and
// pixel frames with random gaps; depends on sb5_pkg, separable_5x5_blur, sb5_blur_checker
`timescale 1ns / 100ps

module tb_separable_5x5_blur;

   localparam int CYCLE_LIMIT = 1500000;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   sb5_pkg::req_type             req_data;
   logic                         rsp_valid;
   logic                         rsp_stall;
   sb5_pkg::rsp_type             rsp_data;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [sb5_pkg::ADDR_W-1:0]   csr_paddr;
   logic [sb5_pkg::DATA_W-1:0]   csr_pwdata;
   logic [sb5_pkg::DATA_W-1:0]   csr_prdata;
   logic                         csr_pready;
   int                           mismatches;
   int                           words_pending;
   int                           pixels_seen;
   int                           words_seen;
   int                           cycles;
   bit                           steady;

   separable_5x5_blur dut (.*);

   sb5_blur_checker checker_i (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_data), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_pready(csr_pready), .mismatches(mismatches),
      .words_pending(words_pending), .pixels_seen(pixels_seen),
      .words_seen(words_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_separable_5x5_blur failed");
         $finish;
      end
   end

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(99);
      if (steady || roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 10);
   endfunction

   // receiver backpressure
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = gap_len();
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
   end

   task automatic send_pixel(input logic [23:0] pix);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = {pix[23:16], pix[15:8], pix[7:0]};
      #1;
      while (req_stall) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [sb5_pkg::DATA_W-1:0] value);
      drain();
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   function automatic logic [23:0] rand_pixel();
      unique case ($urandom_range(9))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic random_frames(input int w_val, input int h_val, input int count);
      write_reg(sb5_pkg::REG_WIDTH, w_val);
      write_reg(sb5_pkg::REG_HEIGHT, h_val);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) steady = ($urandom_range(3) == 0);
         send_pixel(rand_pixel());
      end
      steady = 1'b0;
   endtask

   initial begin
      cycles = 0;
      steady = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // smallest frame, extreme and alternating pixels
      write_reg(sb5_pkg::REG_WIDTH, 5);
      write_reg(sb5_pkg::REG_HEIGHT, 5);
      for (int i = 0; i < 25; i++)
         send_pixel((i % 3 == 0) ? 24'hFFFFFF : (i % 3 == 1) ? 24'h000000 :
                    ((i % 2) ? 24'hFF00FF : 24'h00FF00));

      // sizes below the minimum act as the minimum, two frames back to back
      random_frames(3, 0, 50);
      random_frames(7, 6, 42);
      drain();
      random_frames(7, 6, 21);
      random_frames(12, 6, 72);
      random_frames(5, 8, 40);
      // oversized registers clamp to 2048 wide and 4096 high
      random_frames(4095, 8191, 24);
      random_frames(6, 5, 30);
      drain();
      repeat (20) @(negedge clock);

      $display("sent %0d pixels and checked %0d words over small, clamped and wrapping frames",
               pixels_seen, words_seen);
      if (mismatches == 0 && words_pending == 0) begin
         $display("tb_separable_5x5_blur passed");
      end else begin
         $display("%0d mismatches, %0d words missing", mismatches, words_pending);
         $display("tb_separable_5x5_blur failed");
      end
      $finish;
   end

endmodule
